FILE: design/pfa_pkg.sv
// Shared types and constants for the bitmap page frame allocator.
`default_nettype none
package pfa_pkg;

    localparam int SIZE_W   = 16;
    localparam int BBYTES_W = 11;
    localparam int BCOUNT_W = 6;
    localparam int DIVN_W   = SIZE_W + 1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DUP       = 3'd1;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
    localparam logic [2:0] ST_NO_BLOCKS = 3'd3;
    localparam logic [2:0] ST_UNKNOWN   = 3'd4;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    localparam logic CFG_BLOCK_BYTES = 1'b0;
    localparam logic CFG_BLOCK_COUNT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_SCAN,
        S_REL_RD,
        S_REL_CLR,
        S_RESP
    } state_t;

    typedef struct packed {
        logic                start;
        logic [DIVN_W-1:0]   dividend;
        logic [BBYTES_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVN_W-1:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

FILE: design/pfa_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: design/pfa_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module pfa_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire pfa_pkg::div_req_t req,
    output pfa_pkg::div_rsp_t     rsp
);

    localparam int N_W   = pfa_pkg::DIVN_W;
    localparam int D_W   = pfa_pkg::BBYTES_W;
    localparam int CNT_W = $clog2(N_W + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [N_W-1:0]   quo_reg, quo_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [D_W-1:0]   dvs_reg, dvs_next;
    logic             done_reg, done_next;
    logic [D_W:0]     trial;

    // Shift one dividend bit into the remainder and try a subtract
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[N_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(N_W);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = D_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = D_W'(trial);
                quo_next = {quo_reg[N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
`default_nettype wire

FILE: design/bitmap_page_frame_allocator.sv
// Top level: request sequencer, block bitmap, job tables and page table.
//
//  channel | signals                                       | role
//  --------+-----------------------------------------------+-----------------------
//  in      | in_valid, in_stall, mode, job_id, size_bytes  | allocate/release request
//  out     | out_valid, out_stall, status .. last          | one result per page/request
//  cfg     | cfg_we, cfg_index, cfg_data                   | block_bytes, block_count
//
// Check errors take the check and response states. Allocate takes the check state,
// the divider run, then one scanned bitmap block per cycle (up to MAX_BLOCKS) unless
// an output stall holds a claim. Release takes the check state, a read and a clear
// state per page, set by the registered page-table read, then a response state that output
// stalls hold. Reset clears bitmap, job valid bits, used count; no clearing pass.
`default_nettype none
module bitmap_page_frame_allocator #(
    parameter int MAX_BLOCKS = 32,
    parameter int MAX_JOBS   = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        mode,
    input  wire logic [3:0]  job_id,
    input  wire logic [15:0] size_bytes,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [4:0]       page_number,
    output logic [4:0]       frame_number,
    output logic [10:0]      fill_bytes,
    output logic [5:0]       free_blocks,
    output logic             last,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [10:0] cfg_data
);

    localparam int BW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int UW  = $clog2(MAX_BLOCKS + 1);
    localparam int CW  = (UW > 6) ? UW : 6;
    localparam int JW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int AW  = $clog2(MAX_JOBS * MAX_BLOCKS);
    localparam int BBW = pfa_pkg::BBYTES_W;
    localparam int SW  = pfa_pkg::SIZE_W;
    localparam int NW  = pfa_pkg::DIVN_W;

    pfa_pkg::state_t state_reg, state_next;

    logic [BBW-1:0] bb_reg;
    logic [5:0]     bc_reg;
    logic [MAX_BLOCKS-1:0] used_reg;
    logic [UW-1:0]  used_cnt_reg;
    logic [MAX_JOBS-1:0] jvalid_reg;
    logic [UW-1:0]  jpages_reg [MAX_JOBS];

    logic           mode_reg;
    logic [3:0]     id_reg;
    logic [SW-1:0]  size_reg;
    logic [SW-1:0]  rem_reg;
    logic [UW-1:0]  pages_reg;
    logic [UW-1:0]  pg_reg;
    logic [BW-1:0]  ptr_reg;
    logic [2:0]     st_reg;

    logic           ov_reg;
    logic [2:0]     o_status_reg;
    logic [4:0]     o_page_reg;
    logic [4:0]     o_frame_reg;
    logic [BBW-1:0] o_bytes_reg;
    logic [5:0]     o_free_reg;
    logic           o_last_reg;

    logic [JW-1:0]  jidx;
    logic           id_ok;
    logic [CW-1:0]  eff, free_cnt;
    logic           can_emit;
    logic [AW-1:0]  pt_addr;
    logic [BW-1:0]  pt_rdata;
    logic           claim, advance, scan_last;
    logic [SW-1:0]  take;
    logic           q_fits;
    pfa_pkg::div_req_t dreq;
    pfa_pkg::div_rsp_t drsp;

    assign jidx     = JW'(id_reg);
    assign id_ok    = 7'(id_reg) < 7'(MAX_JOBS);
    assign eff      = (CW'(bc_reg) > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(bc_reg);
    assign free_cnt = (CW'(used_cnt_reg) >= eff) ? '0 : eff - CW'(used_cnt_reg);
    assign can_emit = !ov_reg || !out_stall;
    assign pt_addr  = AW'(jidx) * AW'(MAX_BLOCKS) + AW'(pg_reg);
    assign q_fits   = drsp.quotient <= NW'(free_cnt);
    assign take     = (rem_reg > SW'(bb_reg)) ? SW'(bb_reg) : rem_reg;
    assign scan_last = (pg_reg + UW'(1)) == pages_reg;
    assign claim    = (state_reg == pfa_pkg::S_SCAN) && !used_reg[ptr_reg] && can_emit;
    assign advance  = (state_reg == pfa_pkg::S_SCAN) && (used_reg[ptr_reg] || can_emit);

    // Start the page-count division
    always_comb
    begin
        dreq.start    = (state_reg == pfa_pkg::S_CHECK) && id_ok
                        && (mode_reg == pfa_pkg::MODE_ALLOC) && !jvalid_reg[jidx]
                        && (size_reg != '0) && (bb_reg != '0);
        dreq.dividend = NW'(size_reg) + NW'(bb_reg) - NW'(1);
        dreq.divisor  = bb_reg;
    end

    pfa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    pfa_ram #(
        .WIDTH (BW),
        .DEPTH (MAX_JOBS * MAX_BLOCKS)
    ) u_page_table (
        .clk   (clk),
        .we    (claim),
        .waddr (pt_addr),
        .wdata (ptr_reg),
        .raddr (pt_addr),
        .rdata (pt_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pfa_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = pfa_pkg::S_CHECK;
                end
            end
            pfa_pkg::S_CHECK:
            begin
                if (dreq.start)
                begin
                    state_next = pfa_pkg::S_DIV;
                end
                else if (id_ok && (mode_reg == pfa_pkg::MODE_RELEASE) && jvalid_reg[jidx])
                begin
                    state_next = pfa_pkg::S_REL_RD;
                end
                else
                begin
                    state_next = pfa_pkg::S_RESP;
                end
            end
            pfa_pkg::S_DIV:
            begin
                if (drsp.done)
                begin
                    state_next = q_fits ? pfa_pkg::S_SCAN : pfa_pkg::S_RESP;
                end
            end
            pfa_pkg::S_SCAN:
            begin
                if (claim && scan_last)
                begin
                    state_next = pfa_pkg::S_IDLE;
                end
            end
            pfa_pkg::S_REL_RD:
            begin
                state_next = pfa_pkg::S_REL_CLR;
            end
            pfa_pkg::S_REL_CLR:
            begin
                state_next = ((pg_reg + UW'(1)) >= pages_reg) ? pfa_pkg::S_RESP
                                                              : pfa_pkg::S_REL_RD;
            end
            pfa_pkg::S_RESP:
            begin
                if (can_emit)
                begin
                    state_next = pfa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pfa_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        in_stall = (state_reg != pfa_pkg::S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pfa_pkg::S_IDLE;
            bb_reg       <= BBW'(16);
            bc_reg       <= 6'd32;
            used_reg     <= '0;
            used_cnt_reg <= '0;
            jvalid_reg   <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Configuration writes
            if (cfg_we)
            begin
                if (cfg_index == pfa_pkg::CFG_BLOCK_BYTES)
                begin
                    bb_reg <= cfg_data;
                end
                else
                begin
                    bc_reg <= cfg_data[5:0];
                end
            end

            // Commit an allocation after the division
            if ((state_reg == pfa_pkg::S_DIV) && drsp.done && q_fits)
            begin
                jvalid_reg[jidx] <= 1'b1;
                used_cnt_reg     <= used_cnt_reg + UW'(drsp.quotient);
            end

            // Claim the block under the scan pointer
            if (claim)
            begin
                used_reg[ptr_reg] <= 1'b1;
            end

            // Free one block of the released job
            if (state_reg == pfa_pkg::S_REL_CLR)
            begin
                used_reg[pt_rdata] <= 1'b0;
                if ((pg_reg + UW'(1)) >= pages_reg)
                begin
                    jvalid_reg[jidx] <= 1'b0;
                    used_cnt_reg     <= (used_cnt_reg >= pages_reg)
                                        ? used_cnt_reg - pages_reg : '0;
                end
            end

            // Output register
            if (claim || ((state_reg == pfa_pkg::S_RESP) && can_emit))
            begin
                ov_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // Request fields, counters and result payload
    always_ff @(posedge clk)
    begin
        if ((state_reg == pfa_pkg::S_IDLE) && in_valid)
        begin
            mode_reg <= mode;
            id_reg   <= job_id;
            size_reg <= size_bytes;
        end

        if (state_reg == pfa_pkg::S_CHECK)
        begin
            pg_reg    <= '0;
            pages_reg <= jpages_reg[jidx];
            if (!id_ok)
            begin
                st_reg <= pfa_pkg::ST_UNKNOWN;
            end
            else if (mode_reg == pfa_pkg::MODE_RELEASE)
            begin
                st_reg <= jvalid_reg[jidx] ? pfa_pkg::ST_OK : pfa_pkg::ST_UNKNOWN;
            end
            else if (jvalid_reg[jidx])
            begin
                st_reg <= pfa_pkg::ST_DUP;
            end
            else
            begin
                st_reg <= pfa_pkg::ST_BAD_SIZE;
            end
        end

        if ((state_reg == pfa_pkg::S_DIV) && drsp.done)
        begin
            st_reg    <= pfa_pkg::ST_NO_BLOCKS;
            pages_reg <= UW'(drsp.quotient);
            rem_reg   <= size_reg;
            ptr_reg   <= '0;
            if (q_fits)
            begin
                jpages_reg[jidx] <= UW'(drsp.quotient);
            end
        end

        if (advance)
        begin
            ptr_reg <= ptr_reg + BW'(1);
        end

        if (claim)
        begin
            pg_reg       <= pg_reg + UW'(1);
            rem_reg      <= rem_reg - take;
            o_status_reg <= pfa_pkg::ST_OK;
            o_page_reg   <= 5'(pg_reg);
            o_frame_reg  <= 5'(ptr_reg);
            o_bytes_reg  <= BBW'(take);
            o_free_reg   <= 6'(free_cnt);
            o_last_reg   <= scan_last;
        end

        if (state_reg == pfa_pkg::S_REL_CLR)
        begin
            pg_reg <= pg_reg + UW'(1);
        end

        if ((state_reg == pfa_pkg::S_RESP) && can_emit)
        begin
            o_status_reg <= st_reg;
            o_page_reg   <= '0;
            o_frame_reg  <= '0;
            o_bytes_reg  <= '0;
            o_free_reg   <= 6'(free_cnt);
            o_last_reg   <= 1'b1;
        end
    end

    assign out_valid    = ov_reg;
    assign status       = o_status_reg;
    assign page_number  = o_page_reg;
    assign frame_number = o_frame_reg;
    assign fill_bytes   = o_bytes_reg;
    assign free_blocks  = o_free_reg;
    assign last         = o_last_reg;

endmodule
`default_nettype wire
